/* src/mfpd_pkg.sv */
// ----------------------------------------------------------------------------
// mfpd_pkg
// Shared types and constants for the multi-format PCM decoder.
// ----------------------------------------------------------------------------
package mfpd_pkg;

   typedef enum logic [2:0] {
      FMT_S8    = 3'd0,
      FMT_U8    = 3'd1,
      FMT_S16LE = 3'd2,
      FMT_S16BE = 3'd3,
      FMT_S24LE = 3'd4,
      FMT_S24BE = 3'd5,
      FMT_ONEBIT = 3'd6,
      FMT_DELTA8 = 3'd7
   } sample_format_type;

   typedef logic signed [23:0] sample_type;
   typedef logic [15:0]        delta_acc_type;

   // +/-0.92 rounded into Q1.23
   localparam sample_type ONE_BIT_LEVEL_POS = 24'sd7717519;
   localparam sample_type ONE_BIT_LEVEL_NEG = -24'sd7717519;

   // register index taken from the word address
   localparam logic REG_SAMPLE_FORMAT = 1'b0;

endpackage

/* src/mfpd_channel_decode.sv */
// ----------------------------------------------------------------------------
// mfpd_channel_decode
// Combinational decode of one channel's bytes into a Q1.23 sample, with the
// next value of the channel's delta accumulator.
// ----------------------------------------------------------------------------
module mfpd_channel_decode (
   input  mfpd_pkg::sample_format_type sample_format,
   input  logic [7:0]                  byte0,
   input  logic [7:0]                  byte1,
   input  logic [7:0]                  byte2,
   input  logic [2:0]                  bit_pos,
   input  mfpd_pkg::delta_acc_type     acc,
   output mfpd_pkg::delta_acc_type     acc_next,
   output mfpd_pkg::sample_type        sample
);
   import mfpd_pkg::*;

   delta_acc_type acc_sum;

   // signed byte * 257, modulo 2^16
   assign acc_sum = acc + {byte0, 8'h00} + {{8{byte0[7]}}, byte0};

   always_comb begin
      acc_next = acc;
      case (sample_format)
         FMT_S8:     sample = {byte0, 16'h0000};
         FMT_U8:     sample = {byte0 ^ 8'h80, 16'h0000};
         FMT_S16LE:  sample = {byte1, byte0, 8'h00};
         FMT_S16BE:  sample = {byte0, byte1, 8'h00};
         FMT_S24LE:  sample = {byte2, byte1, byte0};
         FMT_S24BE:  sample = {byte0, byte1, byte2};
         FMT_ONEBIT: sample = byte0[bit_pos] ? ONE_BIT_LEVEL_POS : ONE_BIT_LEVEL_NEG;
         FMT_DELTA8: begin
            acc_next = acc_sum;
            sample   = {acc_sum, 8'h00};
         end
         default:    sample = '0;
      endcase
   end

endmodule

/* src/multi_format_pcm_decoder_top.sv */
// A req beat reaches the rsp beat through the input and result registers.
// Throughput: one stereo frame per cycle unless rsp_stall holds the output;
// the delta accumulators update in the single add of the decode stage.
// Reset: synchronous, active high; clears valids, the format register (s8)
// and both delta accumulators.
// ----------------------------------------------------------------------------
// multi_format_pcm_decoder_top
// Stereo raw PCM decoder: input register, per-channel decode, result register,
// with an APB-style register for the sample format.
// ----------------------------------------------------------------------------
module multi_format_pcm_decoder_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_left_byte0,
   input  logic [7:0]           req_left_byte1,
   input  logic [7:0]           req_left_byte2,
   input  logic [7:0]           req_right_byte0,
   input  logic [7:0]           req_right_byte1,
   input  logic [7:0]           req_right_byte2,
   input  logic [2:0]           req_bit_select,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output mfpd_pkg::sample_type rsp_left_sample,
   output mfpd_pkg::sample_type rsp_right_sample,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [2:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);
   import mfpd_pkg::*;

   sample_format_type fmt_ff;
   delta_acc_type     left_acc_ff, right_acc_ff;
   delta_acc_type     left_acc_in, right_acc_in;
   logic              s1_valid_ff, rsp_valid_ff;
   logic [7:0]        lb0_ff, lb1_ff, lb2_ff, rb0_ff, rb1_ff, rb2_ff;
   logic [2:0]        sel_ff;
   sample_type        left_sample_in, right_sample_in;
   sample_type        left_sample_ff, right_sample_ff;
   logic              out_free, s1_move, req_take;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   // csr
   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_SAMPLE_FORMAT) ? {29'd0, fmt_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff <= FMT_S8;
      end else if (psel && penable && pwrite && paddr[2] == REG_SAMPLE_FORMAT) begin
         fmt_ff <= sample_format_type'(pwdata[2:0]);
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take || s1_move) begin
         s1_valid_ff <= req_take;
      end
      if (req_take) begin
         lb0_ff <= req_left_byte0;
         lb1_ff <= req_left_byte1;
         lb2_ff <= req_left_byte2;
         rb0_ff <= req_right_byte0;
         rb1_ff <= req_right_byte1;
         rb2_ff <= req_right_byte2;
         sel_ff <= req_bit_select;
      end
   end

   mfpd_channel_decode u_left (
      .sample_format (fmt_ff),
      .byte0         (lb0_ff),
      .byte1         (lb1_ff),
      .byte2         (lb2_ff),
      .bit_pos       (sel_ff),
      .acc           (left_acc_ff),
      .acc_next      (left_acc_in),
      .sample        (left_sample_in)
   );

   mfpd_channel_decode u_right (
      .sample_format (fmt_ff),
      .byte0         (rb0_ff),
      .byte1         (rb1_ff),
      .byte2         (rb2_ff),
      .bit_pos       (~sel_ff),
      .acc           (right_acc_ff),
      .acc_next      (right_acc_in),
      .sample        (right_sample_in)
   );

   // result register and delta state
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         left_acc_ff  <= '0;
         right_acc_ff <= '0;
      end else begin
         if (out_free) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         if (s1_move) begin
            left_acc_ff  <= left_acc_in;
            right_acc_ff <= right_acc_in;
         end
      end
      if (s1_move) begin
         left_sample_ff  <= left_sample_in;
         right_sample_ff <= right_sample_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_left_sample  = left_sample_ff;
   assign rsp_right_sample = right_sample_ff;

endmodule
